// ----- design/time_bucket_stats_window_top_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the time bucket statistics window
// Shared property shapes, all clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef TIME_BUCKET_STATS_WINDOW_TOP_MACROS_SVH
`define TIME_BUCKET_STATS_WINDOW_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TBSW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TBSW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- design/tbsw_pkg.sv -----
// ---------------------------------------------------------------------------
// tbsw_pkg
// Types and constants shared by the bucket window controller and datapath.
// ---------------------------------------------------------------------------
package tbsw_pkg;

  localparam int DATA_W    = 64;
  localparam int COUNT_W   = 31;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_SPAN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SPAN = 1'b1;

  // Register values after reset.
  localparam logic [DATA_W-1:0] SPAN_RESET   = 64'd100000;
  localparam logic [DATA_W-1:0] WINDOW_RESET = 64'd900000000;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // One bucket as held in the bucket memory.
  typedef struct packed {
    logic [DATA_W-1:0]  rows_min;
    logic [DATA_W-1:0]  rows_max;
    logic [DATA_W-1:0]  rows_sum;
    logic [DATA_W-1:0]  time_min;
    logic [DATA_W-1:0]  time_max;
    logic [DATA_W-1:0]  time_sum;
    logic [DATA_W-1:0]  bucket_start;
    logic [COUNT_W-1:0] sample_count;
  } entry_t;

  // Which ring position the memory read port addresses.
  typedef enum logic [1:0] {
    RD_INDEX,
    RD_NEWEST,
    RD_OLDEST,
    RD_NEXT_OLDEST
  } rd_src_t;

  // What the result registers load.
  typedef enum logic [2:0] {
    REP_NONE,
    REP_INVALID,
    REP_RAM,
    REP_MERGE,
    REP_PUSH
  } rep_t;

  typedef struct packed {
    logic    load_in;
    logic    rd_en;
    rd_src_t rd_src;
    logic    pop;
    rep_t    rep;
  } cmd_t;

  typedef struct packed {
    logic idx_ok;
    logic total_zero;
    logic total_one;
    logic merge_ok;
    logic expired;
  } status_t;

endpackage

// ----- design/tbsw_ram.sv -----
// ---------------------------------------------------------------------------
// tbsw_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module tbsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/tbsw_ctrl.sv -----
// ---------------------------------------------------------------------------
// tbsw_ctrl
// Sequencer for reads, merges, expiry and pushes of the bucket window.
// ---------------------------------------------------------------------------
`include "time_bucket_stats_window_top_macros.svh"

module tbsw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              func,
  output logic              busy,
  output logic              done,
  input  tbsw_pkg::status_t status,
  output tbsw_pkg::cmd_t    cmd
);

  import tbsw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_DATA,
    S_MRG_CHK,
    S_EXP_CHK,
    S_PUSH
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next  = state;
    cmd.load_in = 1'b0;
    cmd.rd_en   = 1'b0;
    cmd.rd_src  = RD_OLDEST;
    cmd.pop     = 1'b0;
    cmd.rep     = REP_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          if (func) begin
            if (status.idx_ok) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_src = RD_INDEX;
              state_next = S_RD_DATA;
            end else begin
              cmd.rep = REP_INVALID;
            end
          end else if (!status.total_zero) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_src = RD_NEWEST;
            state_next = S_MRG_CHK;
          end else begin
            state_next = S_PUSH;
          end
        end
      end
      S_RD_DATA: begin
        cmd.rep    = REP_RAM;
        state_next = S_IDLE;
      end
      S_MRG_CHK: begin
        if (status.merge_ok) begin
          cmd.rep    = REP_MERGE;
          state_next = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_OLDEST;
          state_next = S_EXP_CHK;
        end
      end
      S_EXP_CHK: begin
        // One bucket is examined per cycle from the oldest end.
        if (status.expired) begin
          cmd.pop = 1'b1;
          if (status.total_one) begin
            state_next = S_PUSH;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_src = RD_NEXT_OLDEST;
          end
        end else begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.rep    = REP_PUSH;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (cmd.rep != REP_NONE);
    end
  end

  // A result is only ever presented once the sequencer is back at rest.
  `TBSW_ASSERT_NOW(a_done_idle, done, state == S_IDLE)
  // An accepted item either finishes at once or keeps the block busy.
  `TBSW_ASSERT_NEXT(a_accept_progress, start && !busy, done || busy)

endmodule

// ----- design/tbsw_dpath.sv -----
// ---------------------------------------------------------------------------
// tbsw_dpath
// Bucket memory, ring pointers, merge and expiry arithmetic, result registers.
// ---------------------------------------------------------------------------
`include "time_bucket_stats_window_top_macros.svh"

module tbsw_dpath #(
  parameter int RING_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tbsw_pkg::cmd_t                      cmd,
  output tbsw_pkg::status_t                   status,
  input  logic [tbsw_pkg::DATA_W-1:0]         rows_found,
  input  logic [tbsw_pkg::DATA_W-1:0]         query_time,
  input  logic [tbsw_pkg::DATA_W-1:0]         sample_time,
  input  logic [5:0]                          record_index,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tbsw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tbsw_pkg::DATA_W-1:0]         cfg_data,
  output logic [6:0]                          occupancy,
  output logic                                entry_valid,
  output tbsw_pkg::entry_t                    result
);

  import tbsw_pkg::*;

  localparam int PW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int IW = (CW > 6) ? CW : 6;

  logic [DATA_W-1:0] bucket_span;
  logic [DATA_W-1:0] window_span;
  logic [DATA_W-1:0] in_rows;
  logic [DATA_W-1:0] in_qtime;
  logic [DATA_W-1:0] in_stamp;
  logic [PW-1:0]     oldest;
  logic [PW-1:0]     oldest_next;
  logic [CW-1:0]     total;
  logic [CW-1:0]     total_next;
  logic [PW-1:0]     rd_addr;
  logic [PW-1:0]     rd_addr_q;
  logic [PW-1:0]     wr_addr;
  logic              wr_en;
  entry_t            wr_data;
  entry_t            rd_q;
  entry_t            merged;
  entry_t            fresh;
  logic [DATA_W-1:0] age;
  logic              full;

  // Ring position at a given offset from the oldest bucket.
  function automatic logic [PW-1:0] ring_pos(input logic [PW-1:0] base,
                                             input logic [SW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + off;
    if (s >= SW'(RING_DEPTH)) begin
      s = s - SW'(RING_DEPTH);
    end
    return s[PW-1:0];
  endfunction

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_span <= SPAN_RESET;
      window_span <= WINDOW_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BUCKET_SPAN: bucket_span <= cfg_data;
        CFG_WINDOW_SPAN: window_span <= cfg_data;
        default: ;
      endcase
    end
  end

  // Item capture at acceptance.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_rows  <= rows_found;
      in_qtime <= query_time;
      in_stamp <= sample_time;
    end
  end

  // Read address selection.
  always_comb begin
    case (cmd.rd_src)
      RD_INDEX:       rd_addr = ring_pos(oldest, SW'(record_index));
      RD_NEWEST:      rd_addr = ring_pos(oldest, SW'(total) - SW'(1));
      RD_OLDEST:      rd_addr = oldest;
      RD_NEXT_OLDEST: rd_addr = ring_pos(oldest, SW'(1));
      default:        rd_addr = oldest;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_addr_q <= rd_addr;
    end
  end

  // Status towards the controller.
  assign age               = in_stamp - rd_q.bucket_start;
  assign status.idx_ok     = IW'(record_index) < IW'(total);
  assign status.total_zero = (total == '0);
  assign status.total_one  = (total == CW'(1));
  assign status.merge_ok   = (age <= bucket_span);
  assign status.expired    = (age > window_span);

  // Newest bucket with the captured sample folded in.
  always_comb begin
    merged.rows_min     = (in_rows < rd_q.rows_min) ? in_rows : rd_q.rows_min;
    merged.rows_max     = (in_rows > rd_q.rows_max) ? in_rows : rd_q.rows_max;
    merged.rows_sum     = rd_q.rows_sum + in_rows;
    merged.time_min     = (in_qtime < rd_q.time_min) ? in_qtime : rd_q.time_min;
    merged.time_max     = (in_qtime > rd_q.time_max) ? in_qtime : rd_q.time_max;
    merged.time_sum     = rd_q.time_sum + in_qtime;
    merged.bucket_start = rd_q.bucket_start;
    merged.sample_count = (rd_q.sample_count != COUNT_MAX) ?
                          rd_q.sample_count + COUNT_W'(1) : rd_q.sample_count;
  end

  // A bucket opened by the captured sample.
  always_comb begin
    fresh.rows_min     = in_rows;
    fresh.rows_max     = in_rows;
    fresh.rows_sum     = in_rows;
    fresh.time_min     = in_qtime;
    fresh.time_max     = in_qtime;
    fresh.time_sum     = in_qtime;
    fresh.bucket_start = in_stamp;
    fresh.sample_count = COUNT_W'(1);
  end

  // Pointer updates and memory writes.
  assign full = (total == CW'(RING_DEPTH));

  always_comb begin
    oldest_next = oldest;
    total_next  = total;
    wr_en       = 1'b0;
    wr_addr     = rd_addr_q;
    wr_data     = merged;
    if (cmd.pop) begin
      oldest_next = ring_pos(oldest, SW'(1));
      total_next  = total - CW'(1);
    end
    case (cmd.rep)
      REP_MERGE: begin
        wr_en = 1'b1;
      end
      REP_PUSH: begin
        wr_en   = 1'b1;
        wr_data = fresh;
        if (full) begin
          // The oldest bucket is overwritten and dropped.
          wr_addr     = oldest;
          oldest_next = ring_pos(oldest, SW'(1));
        end else begin
          wr_addr    = ring_pos(oldest, SW'(total));
          total_next = total + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest <= '0;
      total  <= '0;
    end else begin
      oldest <= oldest_next;
      total  <= total_next;
    end
  end

  tbsw_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (RING_DEPTH)
  ) u_bucket_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rd_q)
  );

  // Result registers.
  always_ff @(posedge clk) begin
    case (cmd.rep)
      REP_INVALID: begin
        occupancy   <= 7'(total_next);
        entry_valid <= 1'b0;
        result      <= '0;
      end
      REP_RAM: begin
        occupancy   <= 7'(total_next);
        entry_valid <= 1'b1;
        result      <= rd_q;
      end
      REP_MERGE: begin
        occupancy   <= 7'(total_next);
        entry_valid <= 1'b1;
        result      <= merged;
      end
      REP_PUSH: begin
        occupancy   <= 7'(total_next);
        entry_valid <= 1'b1;
        result      <= fresh;
      end
      default: ;
    endcase
  end

  // The bucket count never exceeds the ring and the pointer stays inside it.
  `TBSW_ASSERT_NOW(a_ring_bounds, 1'b1,
                   (total <= CW'(RING_DEPTH)) && (SW'(oldest) < SW'(RING_DEPTH)))
  // A push always leaves at least one bucket behind.
  `TBSW_ASSERT_NEXT(a_push_nonempty, cmd.rep == REP_PUSH, total != '0)
  // Expiry never pops from an empty ring.
  `TBSW_ASSERT_NOW(a_pop_nonempty, cmd.pop, total != '0)

endmodule

// ----- design/time_bucket_stats_window_top.sv -----
// ---------------------------------------------------------------------------
// time_bucket_stats_window_top
// Sliding window of time buckets with min, max and sum of two metrics.
// ---------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. func 0 adds a
//   sample (rows_found, query_time, sample_time); func 1 reads the bucket
//   at record_index counted from the oldest. Every item yields one result,
//   shown for a single cycle with done high; the receiver cannot stall it.
//   A read past the end is answered without a memory read; a read waits
//   for the bucket read; a sample reads the newest bucket and merges into
//   it if its age is within bucket_span, else expired buckets are dropped
//   from the oldest end and a new bucket is pushed; into an empty ring it
//   is pushed directly. A new item may be taken in the cycle that done is
//   high. These steps are set by the registered read port of the bucket
//   memory: expiry examines one bucket per cycle from the oldest end.
//   The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
//   writes bucket_span (index 0) or window_span (index 1); cfg_ready is
//   always high. The user writes only while idle; the block does not check.
//   Synchronous reset empties the window and restores the span registers;
//   the bucket memory is not cleared, and no unwritten bucket is ever read.
// ---------------------------------------------------------------------------
module time_bucket_stats_window_top #(
  parameter int RING_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  output logic                           done,
  input  logic                           func,
  input  logic [tbsw_pkg::DATA_W-1:0]    rows_found,
  input  logic [tbsw_pkg::DATA_W-1:0]    query_time,
  input  logic [tbsw_pkg::DATA_W-1:0]    sample_time,
  input  logic [5:0]                     record_index,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tbsw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tbsw_pkg::DATA_W-1:0]    cfg_data,
  output logic [6:0]                     occupancy,
  output logic                           entry_valid,
  output logic [tbsw_pkg::DATA_W-1:0]    rows_min,
  output logic [tbsw_pkg::DATA_W-1:0]    rows_max,
  output logic [tbsw_pkg::DATA_W-1:0]    rows_sum,
  output logic [tbsw_pkg::DATA_W-1:0]    time_min,
  output logic [tbsw_pkg::DATA_W-1:0]    time_max,
  output logic [tbsw_pkg::DATA_W-1:0]    time_sum,
  output logic [tbsw_pkg::DATA_W-1:0]    bucket_start,
  output logic [tbsw_pkg::COUNT_W-1:0]   sample_count
);

  import tbsw_pkg::*;

  cmd_t    cmd;
  status_t status;
  entry_t  result;

  // Sequencer.
  tbsw_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (func),
    .busy   (busy),
    .done   (done),
    .status (status),
    .cmd    (cmd)
  );

  // Bucket storage and arithmetic.
  tbsw_dpath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .rows_found   (rows_found),
    .query_time   (query_time),
    .sample_time  (sample_time),
    .record_index (record_index),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .occupancy    (occupancy),
    .entry_valid  (entry_valid),
    .result       (result)
  );

  // Result fields onto their ports.
  assign rows_min     = result.rows_min;
  assign rows_max     = result.rows_max;
  assign rows_sum     = result.rows_sum;
  assign time_min     = result.time_min;
  assign time_max     = result.time_max;
  assign time_sum     = result.time_sum;
  assign bucket_start = result.bucket_start;
  assign sample_count = result.sample_count;

endmodule
